// File: hw/rtl/assert_macros.svh
// assertion macros of the classifier rtl, used by ipc_dpath
// expects signals clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define IPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define IPC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/ipc_pkg.sv
// shared types, codes and helpers of the ipv4 include/exclude classifier
// no dependencies
package ipc_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int ENT_W  = ADDR_W + LEN_W;

  // item kinds
  localparam logic [1:0] KIND_ADD_INC  = 2'd0;
  localparam logic [1:0] KIND_ADD_EXC  = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  // result codes of an add
  localparam logic [1:0] RC_ADDED   = 2'd0;
  localparam logic [1:0] RC_DUP     = 2'd1;
  localparam logic [1:0] RC_INVALID = 2'd2;
  localparam logic [1:0] RC_FULL    = 2'd3;

  // result codes of a classify
  localparam logic [1:0] RC_OUT_OF_SCOPE = 2'd0;
  localparam logic [1:0] RC_EXCLUDED     = 2'd1;
  localparam logic [1:0] RC_NET_BCAST    = 2'd2;
  localparam logic [1:0] RC_USABLE       = 2'd3;

  localparam logic [LEN_W-1:0] MAX_PREFIX      = 6'd32;
  localparam logic [LEN_W-1:0] SHORT_NET_LIMIT = 6'd31;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  plen;
  } ipc_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ipc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ipc_sts_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= MAX_PREFIX) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/ipc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ipc_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ipc_ctrl.sv
// sequencer of the classifier: accept, table scan, result hand-off
// depends on ipc_pkg
module ipc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output ipc_pkg::ipc_cmd_t cmd_o,
  input  ipc_pkg::ipc_sts_t sts_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/ipc_dpath.sv
// datapath of the classifier: item registers, two prefix tables in ram,
// scan compare, result logic and output register; depends on ipc_pkg, ipc_ram
`include "assert_macros.svh"
module ipc_dpath #(
  parameter int INCLUDE_ENTRIES = 16,
  parameter int EXCLUDE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipc_pkg::ipc_cmd_t            cmd_i,
  output ipc_pkg::ipc_sts_t            sts_o,
  input  logic [1:0]                   in_kind,
  input  logic [ipc_pkg::ADDR_W-1:0]   in_address,
  input  logic [ipc_pkg::LEN_W-1:0]    in_prefix_len,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_result_code,
  output logic                         out_include_found,
  output logic [ipc_pkg::LEN_W-1:0]    out_include_len,
  output logic                         out_exclude_found,
  output logic [ipc_pkg::LEN_W-1:0]    out_exclude_len
);

  localparam int IAW  = (INCLUDE_ENTRIES > 1) ? $clog2(INCLUDE_ENTRIES) : 1;
  localparam int EAW  = (EXCLUDE_ENTRIES > 1) ? $clog2(EXCLUDE_ENTRIES) : 1;
  localparam int ICW  = $clog2(INCLUDE_ENTRIES + 1);
  localparam int ECW  = $clog2(EXCLUDE_ENTRIES + 1);
  localparam int MAXN = (INCLUDE_ENTRIES > EXCLUDE_ENTRIES) ? INCLUDE_ENTRIES
                                                            : EXCLUDE_ENTRIES;
  localparam int IW   = $clog2(MAXN + 1);
  localparam logic [ICW-1:0] INC_CAP = ICW'(INCLUDE_ENTRIES);
  localparam logic [ECW-1:0] EXC_CAP = ECW'(EXCLUDE_ENTRIES);

  // item registers
  logic [1:0]                 kind_r;
  logic [ipc_pkg::ADDR_W-1:0] addr_r;
  logic [ipc_pkg::LEN_W-1:0]  len_r;

  // table fill counts
  logic [ICW-1:0] inc_cnt_r;
  logic [ECW-1:0] exc_cnt_r;

  // scan state
  logic [IW-1:0] idx_r;
  logic          inc_vld_r;
  logic          exc_vld_r;

  // best matches and duplicate flag
  logic                       inc_found_r;
  logic [ipc_pkg::LEN_W-1:0]  inc_len_r;
  logic [ipc_pkg::ADDR_W-1:0] inc_base_r;
  logic                       exc_found_r;
  logic [ipc_pkg::LEN_W-1:0]  exc_len_r;
  logic                       dup_r;

  // output register
  logic                      out_valid_r;
  logic [1:0]                out_code_r;
  logic                      out_inc_found_r;
  logic [ipc_pkg::LEN_W-1:0] out_inc_len_r;
  logic                      out_exc_found_r;
  logic [ipc_pkg::LEN_W-1:0] out_exc_len_r;

  logic                 is_cls;
  logic                 inc_lane;
  logic                 exc_lane;
  logic                 inc_more;
  logic                 exc_more;
  logic                 inc_iss;
  logic                 exc_iss;
  logic                 inc_we;
  logic                 exc_we;
  logic [ipc_pkg::ENT_W-1:0] inc_rdata;
  logic [ipc_pkg::ENT_W-1:0] exc_rdata;
  ipc_pkg::ipc_entry_t  inc_ent;
  ipc_pkg::ipc_entry_t  exc_ent;
  ipc_pkg::ipc_entry_t  new_ent;
  logic                 inc_hit;
  logic                 exc_hit;
  logic                 inc_eq;
  logic                 exc_eq;
  logic [1:0]           fin_code;
  logic [ipc_pkg::ADDR_W-1:0] net_mask;
  logic [ipc_pkg::ADDR_W-1:0] net_addr;
  logic [ipc_pkg::ADDR_W-1:0] bcast_addr;

  // kind three counts as a classify
  assign is_cls   = kind_r[1];
  assign inc_lane = is_cls || (kind_r == ipc_pkg::KIND_ADD_INC);
  assign exc_lane = is_cls || (kind_r == ipc_pkg::KIND_ADD_EXC);
  assign inc_more = inc_lane && (idx_r < IW'(inc_cnt_r));
  assign exc_more = exc_lane && (idx_r < IW'(exc_cnt_r));
  assign inc_iss  = cmd_i.scan && inc_more;
  assign exc_iss  = cmd_i.scan && exc_more;

  assign new_ent.base = addr_r;
  assign new_ent.plen = len_r;

  ipc_ram #(.WIDTH(ipc_pkg::ENT_W), .DEPTH(INCLUDE_ENTRIES)) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (IAW'(inc_cnt_r)),
    .wdata (new_ent),
    .re    (inc_iss),
    .raddr (IAW'(idx_r)),
    .rdata (inc_rdata)
  );

  ipc_ram #(.WIDTH(ipc_pkg::ENT_W), .DEPTH(EXCLUDE_ENTRIES)) u_exc_ram (
    .clk   (clk),
    .we    (exc_we),
    .waddr (EAW'(exc_cnt_r)),
    .wdata (new_ent),
    .re    (exc_iss),
    .raddr (EAW'(idx_r)),
    .rdata (exc_rdata)
  );

  assign inc_ent = inc_rdata;
  assign exc_ent = exc_rdata;

  // containment and exact-match compares on the entry just read
  assign inc_hit = ((addr_r ^ inc_ent.base) & ipc_pkg::prefix_mask(inc_ent.plen)) == '0;
  assign exc_hit = ((addr_r ^ exc_ent.base) & ipc_pkg::prefix_mask(exc_ent.plen)) == '0;
  assign inc_eq  = (inc_ent.base == addr_r) && (inc_ent.plen == len_r);
  assign exc_eq  = (exc_ent.base == addr_r) && (exc_ent.plen == len_r);

  // network and broadcast of the best include entry
  assign net_mask   = ipc_pkg::prefix_mask(inc_len_r);
  assign net_addr   = inc_base_r & net_mask;
  assign bcast_addr = net_addr | ~net_mask;

  always_comb begin
    fin_code = ipc_pkg::RC_ADDED;
    if (is_cls) begin
      if (!inc_found_r) begin
        fin_code = ipc_pkg::RC_OUT_OF_SCOPE;
      end else if (exc_found_r && (exc_len_r > inc_len_r)) begin
        fin_code = ipc_pkg::RC_EXCLUDED;
      end else if ((inc_len_r < ipc_pkg::SHORT_NET_LIMIT) &&
                   ((addr_r == net_addr) || (addr_r == bcast_addr))) begin
        fin_code = ipc_pkg::RC_NET_BCAST;
      end else begin
        fin_code = ipc_pkg::RC_USABLE;
      end
    end else begin
      if ((addr_r == '0) || (len_r > ipc_pkg::MAX_PREFIX)) begin
        fin_code = ipc_pkg::RC_INVALID;
      end else if (dup_r) begin
        fin_code = ipc_pkg::RC_DUP;
      end else if ((kind_r == ipc_pkg::KIND_ADD_INC) ? (inc_cnt_r == INC_CAP)
                                                      : (exc_cnt_r == EXC_CAP)) begin
        fin_code = ipc_pkg::RC_FULL;
      end else begin
        fin_code = ipc_pkg::RC_ADDED;
      end
    end
  end

  assign inc_we = cmd_i.finish && (kind_r == ipc_pkg::KIND_ADD_INC) &&
                  (fin_code == ipc_pkg::RC_ADDED);
  assign exc_we = cmd_i.finish && (kind_r == ipc_pkg::KIND_ADD_EXC) &&
                  (fin_code == ipc_pkg::RC_ADDED);

  assign sts_o.scan_done = !inc_more && !exc_more && !inc_vld_r && !exc_vld_r;
  assign sts_o.out_free  = !out_valid_r || !out_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_cnt_r   <= '0;
      exc_cnt_r   <= '0;
      idx_r       <= '0;
      inc_vld_r   <= 1'b0;
      exc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inc_vld_r <= inc_iss;
      exc_vld_r <= exc_iss;
      if (cmd_i.load) begin
        idx_r <= '0;
      end else if (inc_iss || exc_iss) begin
        idx_r <= idx_r + IW'(1);
      end
      if (inc_we) begin
        inc_cnt_r <= inc_cnt_r + ICW'(1);
      end
      if (exc_we) begin
        exc_cnt_r <= exc_cnt_r + ECW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      kind_r      <= in_kind;
      addr_r      <= in_address;
      len_r       <= in_prefix_len;
      inc_found_r <= 1'b0;
      inc_len_r   <= '0;
      inc_base_r  <= '0;
      exc_found_r <= 1'b0;
      exc_len_r   <= '0;
      dup_r       <= 1'b0;
    end else begin
      // strictly longer wins, so the earliest of equal lengths stays
      if (inc_vld_r && inc_hit && (!inc_found_r || (inc_ent.plen > inc_len_r))) begin
        inc_found_r <= 1'b1;
        inc_len_r   <= inc_ent.plen;
        inc_base_r  <= inc_ent.base;
      end
      if (exc_vld_r && exc_hit && (!exc_found_r || (exc_ent.plen > exc_len_r))) begin
        exc_found_r <= 1'b1;
        exc_len_r   <= exc_ent.plen;
      end
      if ((inc_vld_r && inc_eq) || (exc_vld_r && exc_eq)) begin
        dup_r <= 1'b1;
      end
    end
    if (cmd_i.finish) begin
      out_code_r      <= fin_code;
      out_inc_found_r <= is_cls && inc_found_r;
      out_inc_len_r   <= is_cls ? inc_len_r : '0;
      out_exc_found_r <= is_cls && exc_found_r;
      out_exc_len_r   <= is_cls ? exc_len_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_code   = out_code_r;
  assign out_include_found = out_inc_found_r;
  assign out_include_len   = out_inc_len_r;
  assign out_exclude_found = out_exc_found_r;
  assign out_exclude_len   = out_exc_len_r;

  `IPC_ASSERT(dp_inc_cnt_cap, inc_cnt_r <= INC_CAP, "include count beyond capacity")
  `IPC_ASSERT(dp_exc_cnt_cap, exc_cnt_r <= EXC_CAP, "exclude count beyond capacity")
  `IPC_ASSERT(dp_fin_out, cmd_i.finish |=> out_valid_r, "finished result not registered")
  `IPC_ASSERT_NEVER(dp_write_in_scan, (inc_we || exc_we) && (inc_vld_r || exc_vld_r),
                    "table write while a scan read is in flight")

endmodule

// File: hw/rtl/ipv4_include_exclude_prefix_classifier.sv
// each item scans n entries, n being the target table's fill count for an add and the larger
// of both fill counts for a classify
// one item at a time: a new input transfer is taken only once the last result is in the output
// register; during the scan each table ram is read one entry per cycle
// reset: synchronous active low rst_n empties both tables through their fill counts and
// returns the sequencer to idle; the next input transfer can follow right after reset
//
// top level of the ipv4 include/exclude prefix classifier
// depends on ipc_pkg, ipc_ctrl, ipc_dpath (and ipc_ram inside the datapath)
module ipv4_include_exclude_prefix_classifier #(
  parameter int INCLUDE_ENTRIES = 16,
  parameter int EXCLUDE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [ipc_pkg::ADDR_W-1:0] in_address,
  input  logic [ipc_pkg::LEN_W-1:0]  in_prefix_len,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_result_code,
  output logic                       out_include_found,
  output logic [ipc_pkg::LEN_W-1:0]  out_include_len,
  output logic                       out_exclude_found,
  output logic [ipc_pkg::LEN_W-1:0]  out_exclude_len
);

  // command and status between sequencer and datapath
  ipc_pkg::ipc_cmd_t cmd;
  ipc_pkg::ipc_sts_t sts;

  // sequencer: idle -> scan the tables the item needs -> hand result to the output register;
  // a new transfer is taken in idle even while an earlier result waits
  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // datapath: table rams read one entry per cycle in lockstep, longest prefix
  // tracked per table, adds append at the fill count after a duplicate check
  ipc_dpath #(
    .INCLUDE_ENTRIES (INCLUDE_ENTRIES),
    .EXCLUDE_ENTRIES (EXCLUDE_ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_kind           (in_kind),
    .in_address        (in_address),
    .in_prefix_len     (in_prefix_len),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_code   (out_result_code),
    .out_include_found (out_include_found),
    .out_include_len   (out_include_len),
    .out_exclude_found (out_exclude_found),
    .out_exclude_len   (out_exclude_len)
  );

endmodule

// File: tb/ipv4_include_exclude_prefix_classifier_test.sv
// self-checking testbench of the ipv4 include/exclude prefix classifier
// drives add and classify transfers, predicts each verdict from shadow prefix tables
// depends on ipc_pkg and ipv4_include_exclude_prefix_classifier
module ipv4_include_exclude_prefix_classifier_test;
  import ipc_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // table selectors of the shadow tables
  localparam int NET_INC = 0;
  localparam int NET_EXC = 1;
  // kind code 3 is handled by the block like a classify
  localparam logic [1:0] KIND_CLASSIFY_ALIAS = 2'd3;

  // one result transfer as the block should present it
  typedef struct packed {
    logic [1:0]       code;
    logic             inc_found;
    logic [LEN_W-1:0] inc_len;
    logic             exc_found;
    logic [LEN_W-1:0] exc_len;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_kind;
  logic [ADDR_W-1:0] in_address;
  logic [LEN_W-1:0]  in_prefix_len;

  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_result_code;
  logic              out_include_found;
  logic [LEN_W-1:0]  out_include_len;
  logic              out_exclude_found;
  logic [LEN_W-1:0]  out_exclude_len;

  // shadow copy of both prefix tables, filled in order of addition
  logic [ADDR_W-1:0] net_base [2][TABLE_DEPTH];
  logic [LEN_W-1:0]  net_plen [2][TABLE_DEPTH];
  int                net_fill [2];

  verdict_t pending_verdicts [$];
  int       fail_count;

  // idling control: no_idle turns off both random gaps and random stalls
  bit no_idle;
  int hold_req;
  int hold_left;
  int stall_run;

  ipv4_include_exclude_prefix_classifier #(
    .INCLUDE_ENTRIES(TABLE_DEPTH),
    .EXCLUDE_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_prefix_len    (in_prefix_len),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_code  (out_result_code),
    .out_include_found(out_include_found),
    .out_include_len  (out_include_len),
    .out_exclude_found(out_exclude_found),
    .out_exclude_len  (out_exclude_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // verdict prediction
  // ---------------------------------------------------------------------------

  // network mask of a prefix length, length 0 masks nothing
  function automatic logic [ADDR_W-1:0] host_mask(input logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  // add to one shadow table; duplicate check comes before the full check
  function automatic logic [1:0] table_insert(input int tbl, input logic [ADDR_W-1:0] addr,
                                              input logic [LEN_W-1:0] plen);
    int i;
    if (addr == '0 || plen > MAX_PREFIX) return RC_INVALID;
    for (i = 0; i < net_fill[tbl]; i++) begin
      if (net_base[tbl][i] == addr && net_plen[tbl][i] == plen) return RC_DUP;
    end
    if (net_fill[tbl] >= TABLE_DEPTH) return RC_FULL;
    net_base[tbl][net_fill[tbl]] = addr;
    net_plen[tbl][net_fill[tbl]] = plen;
    net_fill[tbl]++;
    return RC_ADDED;
  endfunction

  // index of the longest entry containing host, earliest wins a tie, -1 if none
  function automatic int longest_entry(input int tbl, input logic [ADDR_W-1:0] host);
    int i;
    int best;
    int best_len;
    best = -1;
    best_len = -1;
    for (i = 0; i < net_fill[tbl]; i++) begin
      if (((host ^ net_base[tbl][i]) & host_mask(net_plen[tbl][i])) == '0 &&
          int'(net_plen[tbl][i]) > best_len) begin
        best = i;
        best_len = int'(net_plen[tbl][i]);
      end
    end
    return best;
  endfunction

  function automatic verdict_t predict_verdict(input logic [1:0] kind,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [LEN_W-1:0] plen);
    verdict_t v;
    int ib;
    int eb;
    int ilen;
    int elen;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] net;
    v = '0;
    if (kind == KIND_ADD_INC) begin
      v.code = table_insert(NET_INC, addr, plen);
      return v;
    end
    if (kind == KIND_ADD_EXC) begin
      v.code = table_insert(NET_EXC, addr, plen);
      return v;
    end
    // classify: prefix length of the item plays no part
    ib = longest_entry(NET_INC, addr);
    eb = longest_entry(NET_EXC, addr);
    ilen = -1;
    elen = -1;
    if (ib >= 0) begin
      ilen = int'(net_plen[NET_INC][ib]);
      v.inc_found = 1'b1;
      v.inc_len = net_plen[NET_INC][ib];
    end
    if (eb >= 0) begin
      elen = int'(net_plen[NET_EXC][eb]);
      v.exc_found = 1'b1;
      v.exc_len = net_plen[NET_EXC][eb];
    end
    if (ib < 0) begin
      v.code = RC_OUT_OF_SCOPE;
    end else if (elen > ilen) begin
      v.code = RC_EXCLUDED;
    end else begin
      v.code = RC_USABLE;
      // base and broadcast come from the masked base, not the stored address
      if (ilen < int'(SHORT_NET_LIMIT)) begin
        m = host_mask(v.inc_len);
        net = net_base[NET_INC][ib] & m;
        if (addr == net || addr == (net | ~m)) v.code = RC_NET_BCAST;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // mostly back to back, often a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer; valid stays high into the next item when there is no gap
  task automatic offer_item(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] plen);
    int gap;
    verdict_t want_v;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_address    <= addr;
    in_prefix_len <= plen;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge, tables move on in input order
    want_v = predict_verdict(kind, addr, plen);
    pending_verdicts = {pending_verdicts, want_v};
  endtask

  // drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // random item: mostly classifies aimed at stored networks, the rest adds
  task automatic random_item(output logic [1:0] kind, output logic [ADDR_W-1:0] addr,
                             output logic [LEN_W-1:0] plen);
    int r;
    int tbl;
    int idx;
    logic [ADDR_W-1:0] m;
    logic [LEN_W-1:0] parent_len;
    r = $urandom_range(0, 99);
    addr = $urandom;
    tbl = $urandom_range(NET_INC, NET_EXC);
    if (r < 70) begin
      kind = ($urandom_range(0, 9) == 0) ? KIND_CLASSIFY_ALIAS : KIND_CLASSIFY;
      plen = LEN_W'($urandom_range(0, 63));
      if ($urandom_range(0, 4) != 0 && net_fill[tbl] > 0) begin
        // host inside a stored network: its base, its broadcast or any host
        idx = $urandom_range(0, net_fill[tbl] - 1);
        m = host_mask(net_plen[tbl][idx]);
        case ($urandom_range(0, 3))
          0: begin
            addr = net_base[tbl][idx] & m;
          end
          1: begin
            addr = net_base[tbl][idx] | ~m;
          end
          default: begin
            addr = (net_base[tbl][idx] & m) | (addr & ~m);
          end
        endcase
      end
    end else begin
      kind = (tbl == NET_INC) ? KIND_ADD_INC : KIND_ADD_EXC;
      plen = LEN_W'($urandom_range(1, 32));
      r = $urandom_range(0, 99);
      if (r < 5) begin
        addr = '0;
        plen = LEN_W'($urandom_range(0, 63));
      end else if (r < 10) begin
        plen = LEN_W'($urandom_range(33, 63));
      end else if (r < 20 && net_fill[tbl] > 0) begin
        idx = $urandom_range(0, net_fill[tbl] - 1);
        addr = net_base[tbl][idx];
        plen = net_plen[tbl][idx];
      end else if (r < 55 && net_fill[NET_INC] > 0) begin
        // subnet of an include network, host bits left in the address
        idx = $urandom_range(0, net_fill[NET_INC] - 1);
        parent_len = net_plen[NET_INC][idx];
        plen = LEN_W'($urandom_range(parent_len, 32));
        m = host_mask(parent_len);
        addr = (net_base[NET_INC][idx] & m) | (addr & ~m);
      end else if (r < 57) begin
        plen = '0;
      end
    end
  endtask

  task automatic offer_random(input int count);
    logic [1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0] plen;
    repeat (count) begin
      random_item(kind, addr, plen);
      offer_item(kind, addr, plen);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall: runs of random length, a requested long hold wins
  always @(posedge clk) begin : stall_drive
    int r;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 6);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(15, 50);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // each result transfer is matched with the oldest outstanding verdict
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no verdict outstanding: result_code %0d",
               out_result_code);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("result_code", 32'(want.code), 32'(out_result_code));
        check_field("include_found", 32'(want.inc_found), 32'(out_include_found));
        check_field("include_len", 32'(want.inc_len), 32'(out_include_len));
        check_field("exclude_found", 32'(want.exc_found), 32'(out_exclude_found));
        check_field("exclude_len", 32'(want.exc_len), 32'(out_exclude_len));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // both tables still empty: nothing can be in scope
  task automatic test_empty_tables();
    offer_item(KIND_CLASSIFY, 32'h0000_0000, 6'd0);
    offer_item(KIND_CLASSIFY_ALIAS, 32'hFFFF_FFFF, 6'd63);
  endtask

  // zero address and over-long prefixes are refused by both tables
  task automatic test_add_rejects();
    offer_item(KIND_ADD_INC, 32'h0000_0000, 6'd8);
    offer_item(KIND_ADD_EXC, 32'h0000_0000, 6'd0);
    offer_item(KIND_ADD_INC, 32'h0102_0304, 6'd33);
    offer_item(KIND_ADD_EXC, 32'hFFFF_FFFF, 6'd63);
  endtask

  // fresh adds, repeated adds, a base with host bits, /31 and /32 networks,
  // and an exclude as long as its include
  task automatic test_add_and_duplicate();
    offer_item(KIND_ADD_INC, 32'h0A00_0000, 6'd8);
    offer_item(KIND_ADD_INC, 32'h0A00_0000, 6'd8);
    offer_item(KIND_ADD_EXC, 32'h0A01_0000, 6'd16);
    offer_item(KIND_ADD_EXC, 32'h0A01_0000, 6'd16);
    offer_item(KIND_ADD_INC, 32'hC0A8_014D, 6'd24);
    offer_item(KIND_ADD_INC, 32'hAC10_0001, 6'd31);
    offer_item(KIND_ADD_INC, 32'hFFFF_FFFF, 6'd32);
    offer_item(KIND_ADD_EXC, 32'h0AFF_0000, 6'd8);
  endtask

  // every classify outcome against the networks added above
  task automatic test_classify_cases();
    offer_item(KIND_CLASSIFY, 32'h0A00_0000, 6'd0);   // base of 10/8, equal-length exclude
    offer_item(KIND_CLASSIFY, 32'h0AFF_FFFF, 6'd0);   // broadcast of 10/8
    offer_item(KIND_CLASSIFY, 32'h0A01_0203, 6'd0);   // longer exclude wins
    offer_item(KIND_CLASSIFY, 32'h0A02_0304, 6'd32);  // usable
    offer_item(KIND_CLASSIFY, 32'hC0A8_0100, 6'd0);   // masked base, not the stored one
    offer_item(KIND_CLASSIFY, 32'hC0A8_01FF, 6'd0);   // broadcast of the /24
    offer_item(KIND_CLASSIFY, 32'hC0A8_014D, 6'd0);   // the stored address itself
    offer_item(KIND_CLASSIFY, 32'hAC10_0000, 6'd0);   // /31 has no base or broadcast
    offer_item(KIND_CLASSIFY, 32'hFFFF_FFFF, 6'd0);   // /32 host
    offer_item(KIND_CLASSIFY_ALIAS, 32'h0B00_0000, 6'd0);  // out of scope
  endtask

  // no gaps and no stalls on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    offer_random(100);
    wait_drained();
    no_idle = 1'b0;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input
  task automatic test_result_hold();
    no_idle = 1'b1;
    hold_req = 300;
    offer_random(24);
    wait_drained();
    no_idle = 1'b0;
  endtask

  // bulk of the run: tables fill up, later adds run into the full check
  task automatic test_random_traffic();
    offer_random(1600);
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    offer_random(10);
    wait_drained();
    offer_random(10);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_CLASSIFY;
    in_address    = '0;
    in_prefix_len = '0;
    out_stall     = 1'b0;
    fail_count    = 0;
    no_idle       = 1'b0;
    hold_req      = 0;
    hold_left     = 0;
    stall_run     = 0;
    net_fill[NET_INC] = 0;
    net_fill[NET_EXC] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tables();
    test_add_rejects();
    test_add_and_duplicate();
    test_classify_cases();
    test_back_to_back();
    test_result_hold();
    test_random_traffic();
    test_drain_pause();

    // last results, then a margin for anything stray from the block
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_ram.sv
hw/rtl/ipc_ctrl.sv
hw/rtl/ipc_dpath.sv
hw/rtl/ipv4_include_exclude_prefix_classifier.sv
tb/ipv4_include_exclude_prefix_classifier_test.sv
